// ----- rtl/cfla_pkg.sv -----
// shared constants, codes and controller/datapath interface types for the chunk allocator
package cfla_pkg;

	// sizing
	localparam int MAX_CHUNKS = 1024;
	localparam int ADDR_W     = 48;
	localparam int SIZE_W     = 17;
	localparam int CHUNKS_W   = 11;
	localparam int REQ_W      = 20;
	localparam int OP_W       = 2;
	localparam int STAT_W     = 3;
	localparam int BITS_PER_BYTE = 8;
	localparam int CLR_W      = 8;

	localparam int CNT_W  = $clog2(MAX_CHUNKS + 1);
	localparam int IDX_W  = $clog2(MAX_CHUNKS);
	localparam int M_W    = $clog2((MAX_CHUNKS + BITS_PER_BYTE - 1) / BITS_PER_BYTE + 1);
	localparam int ITER_W = (M_W > 1) ? $clog2(M_W) : 1;
	localparam int PROD_W = CNT_W + SIZE_W;
	localparam int SUM_W  = ((ADDR_W > PROD_W) ? ADDR_W : PROD_W) + 1;
	localparam int CFG_W  = (ADDR_W > SIZE_W) ? ADDR_W : SIZE_W;
	localparam int REG_IDX_W = 2;

	// register reset values
	localparam logic [SIZE_W-1:0]   SIZE_RST   = SIZE_W'(256);
	localparam logic [CHUNKS_W-1:0] CHUNKS_RST = CHUNKS_W'(1024);

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_BASE   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SIZE   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CHUNKS = 2'd2;

	// operations
	localparam logic [OP_W-1:0] OP_ALLOC    = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE     = 2'd1;
	localparam logic [OP_W-1:0] OP_FREE_CUR = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
	localparam logic [STAT_W-1:0] STAT_BAD_SIZE = 3'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd2;
	localparam logic [STAT_W-1:0] STAT_LAST     = 3'd3;
	localparam logic [STAT_W-1:0] STAT_OVERFLOW = 3'd4;

	// controller to datapath
	typedef struct packed {
		logic init_load;
		logic div_step;
		logic fresh_load;
		logic mul_load;
		logic add_load;
		logic accept;
		logic finish;
	} cfla_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_last;
		logic cfg_hit;
	} cfla_sts_t;

endpackage

// ----- rtl/cfla_ram.sv -----
// generic single-write, single-read ram with registered read data
module cfla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/cfla_ctrl.sv -----
// sequencing fsm for pool init and per-request execution
module cfla_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  cfla_pkg::cfla_sts_t sts,
	output cfla_pkg::cfla_cmd_t cmd,
	output logic                busy,
	output logic                done
);
	import cfla_pkg::*;

	localparam logic [2:0] S_LOAD  = 3'd0;
	localparam logic [2:0] S_DIV   = 3'd1;
	localparam logic [2:0] S_FRESH = 3'd2;
	localparam logic [2:0] S_MUL   = 3'd3;
	localparam logic [2:0] S_ADD   = 3'd4;
	localparam logic [2:0] S_IDLE  = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       done_q;

	always_comb begin
		cmd            = '0;
		cmd.init_load  = (state_q == S_LOAD);
		cmd.div_step   = (state_q == S_DIV);
		cmd.fresh_load = (state_q == S_FRESH);
		cmd.mul_load   = (state_q == S_MUL);
		cmd.add_load   = (state_q == S_ADD);
		cmd.accept     = (state_q == S_IDLE) && start && !sts.cfg_hit;
		cmd.finish     = (state_q == S_FIN);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_LOAD:  state_d = S_DIV;
			S_DIV:   if (sts.div_last) begin
				state_d = S_FRESH;
			end
			S_FRESH: state_d = S_MUL;
			S_MUL:   state_d = S_ADD;
			S_ADD:   state_d = S_IDLE;
			S_IDLE:  if (cmd.accept) begin
				state_d = S_FIN;
			end
			S_FIN:   state_d = S_IDLE;
			default: state_d = S_LOAD;
		endcase
		// any write to a listed register restarts pool init
		if (sts.cfg_hit) begin
			state_d = S_LOAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.finish;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	a_accept_then_fin: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == S_FIN))
		else $error("accepted request not followed by finish cycle");

	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == S_FIN))
		else $error("result strobe without finish cycle");

	a_accept_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> !busy)
		else $error("request taken while busy");

endmodule

// ----- rtl/cfla_dp.sv -----
// datapath: config registers, init divider, stack bookkeeping and result registers
module cfla_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cfla_pkg::cfla_cmd_t                 cmd,
	output cfla_pkg::cfla_sts_t                 sts,
	input  logic                                cfg_write,
	input  logic [cfla_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [cfla_pkg::CFG_W-1:0]          cfg_wdata,
	input  logic [cfla_pkg::OP_W-1:0]           operation,
	input  logic [cfla_pkg::REQ_W-1:0]          request_size,
	input  logic [cfla_pkg::ADDR_W-1:0]         address,
	input  logic [cfla_pkg::ADDR_W-1:0]         prev_address,
	output logic [cfla_pkg::STAT_W-1:0]         status,
	output logic [cfla_pkg::ADDR_W-1:0]         alloc_address,
	output logic [cfla_pkg::ADDR_W-1:0]         next_address,
	output logic [cfla_pkg::ADDR_W-1:0]         previous_alloc
);
	import cfla_pkg::*;

	// config
	logic [ADDR_W-1:0]   base_q;
	logic [SIZE_W-1:0]   size_q;
	logic [CHUNKS_W-1:0] chunks_q;
	logic [SIZE_W-1:0]   esize_q;
	logic [CNT_W-1:0]    n_q;

	// init divider
	logic [M_W-1:0]    dq_q;
	logic [SIZE_W-1:0] rem_q;
	logic [ITER_W-1:0] iter_q;
	logic [SIZE_W:0]   trial;
	logic [PROD_W-1:0] prod_q;

	// pool state
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  fresh_q;
	logic [ADDR_W-1:0] fa_q;
	logic [ADDR_W-1:0] top_q;
	logic [ADDR_W-1:0] last_q;

	// pending result
	logic [STAT_W-1:0] stat_p_q;
	logic [ADDR_W-1:0] got_p_q;
	logic [ADDR_W-1:0] prior_p_q;
	logic [ADDR_W-1:0] next_p_q;
	logic              ram_sel_q;

	// output registers
	logic [STAT_W-1:0] status_q;
	logic [ADDR_W-1:0] alloc_q;
	logic [ADDR_W-1:0] next_q;
	logic [ADDR_W-1:0] prev_q;

	// next values at accept
	logic [CNT_W-1:0]  n_count;
	logic [CNT_W-1:0]  n_fresh;
	logic [ADDR_W-1:0] n_fa;
	logic [ADDR_W-1:0] n_top;
	logic [ADDR_W-1:0] n_last;
	logic [STAT_W-1:0] n_stat;
	logic [ADDR_W-1:0] n_got;
	logic [ADDR_W-1:0] n_prior;
	logic [ADDR_W-1:0] n_next;
	logic              n_ram_sel;
	logic              ok_alloc;
	logic              popped;
	logic              push;
	logic [ADDR_W-1:0] taken;
	logic              bad_size;

	// init helpers
	logic [CNT_W-1:0]  n_eff;
	logic [M_W-1:0]    bytes_m;
	logic [SIZE_W-1:0] esize_d;
	logic [CNT_W-1:0]  rd_cnt;
	logic [ADDR_W-1:0] rdata;

	assign sts.cfg_hit  = cfg_write &&
		(cfg_index inside {REG_BASE, REG_SIZE, REG_CHUNKS});
	assign sts.div_last = (iter_q == ITER_W'(M_W - 1));

	always_comb begin
		esize_d = (size_q == '0) ? SIZE_W'(1) : size_q;
		n_eff   = (int'(chunks_q) > MAX_CHUNKS) ? CNT_W'(MAX_CHUNKS) : CNT_W'(chunks_q);
		bytes_m = M_W'(({1'b0, n_eff} + (CNT_W + 1)'(BITS_PER_BYTE - 1)) >> 3);
		trial   = {rem_q, dq_q[M_W-1]};
	end

	// request decode
	always_comb begin
		n_count   = count_q;
		n_fresh   = fresh_q;
		n_fa      = fa_q;
		n_top     = top_q;
		n_last    = last_q;
		n_stat    = STAT_OK;
		n_got     = '0;
		ok_alloc  = 1'b0;
		popped    = 1'b0;
		push      = 1'b0;
		taken     = fa_q;
		bad_size  = (request_size == '0) || (request_size > REQ_W'(esize_q));
		case (operation)
			OP_ALLOC: begin
				if (bad_size) begin
					n_stat = STAT_BAD_SIZE;
				end else if (count_q == '0 && fresh_q >= n_q) begin
					n_stat = STAT_EMPTY;
				end else begin
					if (count_q != '0) begin
						taken   = top_q;
						n_count = count_q - CNT_W'(1);
						popped  = 1'b1;
					end else begin
						taken   = fa_q;
						n_fresh = fresh_q + CNT_W'(1);
						n_fa    = ADDR_W'(SUM_W'(fa_q) + SUM_W'(esize_q));
					end
					if (n_count == '0 && n_fresh >= n_q) begin
						n_stat = STAT_LAST;
					end else begin
						n_got    = taken;
						n_last   = taken;
						ok_alloc = 1'b1;
					end
				end
			end
			OP_FREE, OP_FREE_CUR: begin
				if (count_q >= CNT_W'(MAX_CHUNKS)) begin
					n_stat = STAT_OVERFLOW;
				end else begin
					push    = 1'b1;
					n_count = count_q + CNT_W'(1);
					n_top   = address;
					if (operation == OP_FREE_CUR) begin
						n_last = {prev_address[ADDR_W-1:CLR_W], CLR_W'(0)};
					end
				end
			end
			default: ;
		endcase
		n_prior   = ok_alloc ? last_q : n_last;
		n_ram_sel = popped && (n_count != '0);
		if (n_count != '0) begin
			n_next = n_top;
		end else if (n_fresh < n_q) begin
			n_next = n_fa;
		end else begin
			n_next = '0;
		end
	end

	// entry below the top becomes the new top after a pop
	assign rd_cnt = count_q - CNT_W'(2);

	cfla_ram #(
		.WIDTH(ADDR_W),
		.DEPTH(MAX_CHUNKS)
	) u_stack (
		.clk  (clk),
		.we   (cmd.accept && push),
		.waddr(count_q[IDX_W-1:0]),
		.wdata(address),
		.re   (cmd.accept),
		.raddr(rd_cnt[IDX_W-1:0]),
		.rdata(rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			size_q   <= SIZE_RST;
			chunks_q <= CHUNKS_RST;
			count_q  <= '0;
			fresh_q  <= '0;
			last_q   <= '0;
			iter_q   <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_BASE:   base_q   <= cfg_wdata[ADDR_W-1:0];
					REG_SIZE:   size_q   <= cfg_wdata[SIZE_W-1:0];
					REG_CHUNKS: chunks_q <= cfg_wdata[CHUNKS_W-1:0];
					default: ;
				endcase
			end
			if (cmd.init_load) begin
				count_q <= '0;
				last_q  <= '0;
				iter_q  <= '0;
			end
			if (cmd.div_step) begin
				iter_q <= iter_q + ITER_W'(1);
			end
			if (cmd.fresh_load) begin
				fresh_q <= CNT_W'(dq_q) + CNT_W'(rem_q != '0);
			end
			if (cmd.accept) begin
				count_q <= n_count;
				fresh_q <= n_fresh;
				last_q  <= n_last;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.init_load) begin
			esize_q <= esize_d;
			n_q     <= n_eff;
			dq_q    <= bytes_m;
			rem_q   <= '0;
		end
		if (cmd.div_step) begin
			if (trial >= {1'b0, esize_q}) begin
				rem_q <= SIZE_W'(trial - {1'b0, esize_q});
				dq_q  <= {dq_q[M_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[SIZE_W-1:0];
				dq_q  <= {dq_q[M_W-2:0], 1'b0};
			end
		end
		if (cmd.mul_load) begin
			prod_q <= PROD_W'(fresh_q) * PROD_W'(esize_q);
		end
		if (cmd.add_load) begin
			fa_q <= ADDR_W'(SUM_W'(base_q) + SUM_W'(prod_q));
		end
		if (cmd.accept) begin
			fa_q      <= n_fa;
			top_q     <= n_top;
			stat_p_q  <= n_stat;
			got_p_q   <= n_got;
			prior_p_q <= n_prior;
			next_p_q  <= n_next;
			ram_sel_q <= n_ram_sel;
		end
		if (cmd.finish) begin
			if (ram_sel_q) begin
				top_q <= rdata;
			end
			status_q <= stat_p_q;
			alloc_q  <= got_p_q;
			next_q   <= ram_sel_q ? rdata : next_p_q;
			prev_q   <= prior_p_q;
		end
	end

	assign status         = status_q;
	assign alloc_address  = alloc_q;
	assign next_address   = next_q;
	assign previous_alloc = prev_q;

	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && push) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("push did not advance stack count");

	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> (fresh_q <= n_q))
		else $error("fresh index beyond chunk count");

	a_ram_top_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && ram_sel_q) |-> (count_q != '0))
		else $error("stack top reload with empty stack");

endmodule

// ----- rtl/chunk_free_list_allocator.sv -----
// top level of the lifo chunk free-list allocator
// Hands out fixed-size chunks of a region that starts at base_address, chunk i at
// base_address + i times the chunk size. The leading bitmap chunks, ceil(chunks / (8 * size)),
// are never handed out. Freed addresses go on a stack held in a ram of MAX_CHUNKS
// entries with one write and one registered read port; fresh chunks lie below that
// stack in ascending order. A request beat is taken when start is high and busy is
// low; its result shows on the result ports for exactly one cycle with done high,
// starting one cycle after the accepting edge, and the next request may be taken at
// the edge that ends that cycle. Each request takes an accept step, which updates the pool
// and launches the read of the entry below the top, then a finish step in which the registered
// ram read data arrives. After reset and after every write to a listed register the pool
// is rebuilt: an 8-step shift-subtract divider works out the bitmap chunk count, then a
// multiply and an add place the first fresh address, with busy high throughout. Register
// writes are taken at any edge with cfg_write high; one to a listed index blocks a request
// in that cycle, one past the register list is ignored. The receiver cannot stall results.
module chunk_free_list_allocator (
	input  logic                            clk,
	input  logic                            arst_n,
	// request
	input  logic                            start,
	output logic                            busy,
	input  logic [cfla_pkg::OP_W-1:0]       operation,
	input  logic [cfla_pkg::REQ_W-1:0]      request_size,
	input  logic [cfla_pkg::ADDR_W-1:0]     address,
	input  logic [cfla_pkg::ADDR_W-1:0]     prev_address,
	// result
	output logic                            done,
	output logic [cfla_pkg::STAT_W-1:0]     status,
	output logic [cfla_pkg::ADDR_W-1:0]     alloc_address,
	output logic [cfla_pkg::ADDR_W-1:0]     next_address,
	output logic [cfla_pkg::ADDR_W-1:0]     previous_alloc,
	// register writes
	input  logic                            cfg_write,
	input  logic [cfla_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [cfla_pkg::CFG_W-1:0]      cfg_wdata
);
	import cfla_pkg::*;

	cfla_cmd_t cmd;
	cfla_sts_t sts;

	// sequencing: init steps, then an accept cycle and a finish cycle per beat
	cfla_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	// registers, divider, stack ram and result registers
	cfla_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.operation     (operation),
		.request_size  (request_size),
		.address       (address),
		.prev_address  (prev_address),
		.status        (status),
		.alloc_address (alloc_address),
		.next_address  (next_address),
		.previous_alloc(previous_alloc)
	);

endmodule
